/* hw/rtl/assert_macros.svh */
// assertion macros for the deinterlacer rtl
// no dependencies; checks vanish when SYNTHESIS is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define MADI_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
`define MADI_NEVER(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("forbidden condition seen");
`else
`define MADI_ASSERT(lbl, clk, rst_n, prop)
`define MADI_NEVER(lbl, clk, rst_n, expr)
`endif
`endif

/* hw/rtl/madi_pkg.sv */
// shared types, register indexes and helpers for the deinterlacer
// no dependencies
package madi_pkg;

    typedef struct packed {
        logic [15:0] cdiff;   // |weave - vertical average|
        logic [15:0] tdiff;   // |weave - other time|
        logic [15:0] lower;
        logic [15:0] upper;
        logic [15:0] other;
        logic [15:0] weave;
    } col_t;

    typedef enum logic [1:0] {
        CFG_MOTION = 2'd0,
        CFG_COMB   = 2'd1,
        CFG_FLOOR  = 2'd2,
        CFG_NONE   = 2'd3
    } cfg_idx_t;

    localparam logic [15:0] MOTION_RESET = 16'd1024;
    localparam logic [15:0] COMB_RESET   = 16'd1536;
    localparam logic [15:0] FLOOR_RESET  = 16'd256;

    function automatic logic [15:0] absdiff16(input logic [15:0] a, input logic [15:0] b);
        logic [15:0] r;
        r = (a > b) ? (a - b) : (b - a);
        return r;
    endfunction

    function automatic logic [15:0] avg2(input logic [15:0] a, input logic [15:0] b);
        logic [16:0] s;
        s = {1'b0, a} + {1'b0, b} + 17'd1;
        return s[16:1];
    endfunction

endpackage

/* hw/rtl/motion_adaptive_deinterlace_line.sv */
// channel   dir  handshake                 contents
// s_axis    in   s_tvalid/s_tready         one column: four samples, line_active, last_in_line
// m_axis    out  m_tvalid/m_tready         one pixel of the column four columns back
// cfg       in   cfg_valid/cfg_ready       register index and 16-bit value, always ready
// one word a cycle in steady flow; column x leaves after column x+MASK_REACH+1 arrives,
// then passes through the job queue and the registers of the back part
// a word with tlast makes the back part emit up to MASK_REACH+2 pixels, one a cycle while
// m_tready holds, none for an absent slot; the two-entry job queue lets input run on meanwhile
// s_tready drops only when the job queue is full; reset clears flags, counts, loads cfg defaults
// depends on madi_pkg, madi_front, madi_queue, madi_back
module motion_adaptive_deinterlace_line import madi_pkg::*; #(
    parameter int MASK_REACH = 3
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // weave_sample, other_time_sample, upper_sample, lower_sample
    input  logic        s_tuser,   // line_active
    input  logic        s_tlast,   // last_in_line
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // pixel
    output logic        m_tuser,   // was_interpolated
    output logic        m_tlast,   // line_end
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);
    localparam int JW = 2 + (2 * MASK_REACH + 3) * (1 + $bits(col_t));

    logic [15:0] motion_reg, comb_reg, floor_reg;
    logic          q_push, q_full, q_pop, q_valid;
    logic [JW-1:0] q_in, q_head;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            motion_reg <= MOTION_RESET;
            comb_reg   <= COMB_RESET;
            floor_reg  <= FLOOR_RESET;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_MOTION: motion_reg <= cfg_data;
                CFG_COMB:   comb_reg   <= cfg_data;
                CFG_FLOOR:  floor_reg  <= cfg_data;
                default:    ;
            endcase
        end
    end

    madi_front #(.MASK_REACH(MASK_REACH)) u_front (
        .clk(clk), .rst_n(rst_n),
        .in_valid(s_tvalid), .in_ready(s_tready), .in_data(s_tdata),
        .in_active(s_tuser), .in_last(s_tlast),
        .q_full(q_full), .q_push(q_push), .q_data(q_in)
    );

    madi_queue #(.DW(JW)) u_queue (
        .clk(clk), .rst_n(rst_n),
        .push(q_push), .push_data(q_in), .full(q_full),
        .pop(q_pop), .head_valid(q_valid), .head_data(q_head)
    );

    madi_back #(.MASK_REACH(MASK_REACH)) u_back (
        .clk(clk), .rst_n(rst_n),
        .q_valid(q_valid), .q_pop(q_pop), .q_data(q_head),
        .motion_thr(motion_reg), .comb_thr(comb_reg), .floor_thr(floor_reg),
        .out_valid(m_tvalid), .out_ready(m_tready), .out_pixel(m_tdata),
        .out_interp(m_tuser), .out_last(m_tlast)
    );

endmodule

/* hw/rtl/madi_front.sv */
// front: column window, line flags and job building
// depends on madi_pkg
module madi_front import madi_pkg::*; #(
    parameter int MASK_REACH = 3
) (
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    input  logic [63:0] in_data,
    input  logic in_active,
    input  logic in_last,
    input  logic q_full,
    output logic q_push,
    output logic [2 + (2 * MASK_REACH + 3) * (1 + $bits(col_t)) - 1:0] q_data
);
    localparam int WIN = 2 * MASK_REACH + 3;
    localparam int SLOT = MASK_REACH + 1;
    localparam int CW = $bits(col_t);

    col_t           win_reg [WIN];
    logic [WIN-1:0] valid_reg;
    logic [3:0]     seen_reg;
    logic           held_reg;

    col_t           win_next [WIN];
    logic [WIN-1:0] valid_next;
    logic           held_next;
    col_t           col_new;
    logic           accept;

    assign in_ready = !q_full;
    assign accept = in_valid && in_ready;

    always_comb
    begin
        col_new.weave = in_data[15:0];
        col_new.other = in_data[31:16];
        col_new.upper = in_data[47:32];
        col_new.lower = in_data[63:48];
        col_new.tdiff = absdiff16(in_data[15:0], in_data[31:16]);
        col_new.cdiff = absdiff16(in_data[15:0], avg2(in_data[47:32], in_data[63:48]));
        win_next[0] = col_new;
        for (int i = 1; i < WIN; i++)
        begin
            win_next[i] = win_reg[i-1];
        end
        valid_next = {valid_reg[WIN-2:0], 1'b1};
        held_next = (seen_reg == 4'd0) ? in_active : held_reg;
        for (int i = 0; i < WIN; i++)
        begin
            q_data[i*CW +: CW] = win_next[i];
        end
        q_data[WIN*CW +: WIN] = valid_next;
        q_data[WIN*CW + WIN] = held_next;
        q_data[WIN*CW + WIN + 1] = in_last;
    end

    // a word only makes a job once the emitted slot holds a column, or on flush
    assign q_push = accept && (in_last || valid_next[SLOT]);

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            for (int i = 0; i < WIN; i++)
            begin
                win_reg[i] <= win_next[i];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            seen_reg  <= 4'd0;
            held_reg  <= 1'b0;
        end
        else if (accept)
        begin
            if (in_last)
            begin
                valid_reg <= '0;
                seen_reg  <= 4'd0;
                held_reg  <= 1'b0;
            end
            else
            begin
                valid_reg <= valid_next;
                seen_reg  <= (seen_reg == 4'd15) ? seen_reg : seen_reg + 4'd1;
                held_reg  <= held_next;
            end
        end
    end

endmodule

/* hw/rtl/madi_queue.sv */
// two-entry job queue between front and back
// depends on assert_macros.svh
`include "assert_macros.svh"
module madi_queue #(
    parameter int DW = 8
) (
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  logic [DW-1:0] push_data,
    output logic full,
    input  logic pop,
    output logic head_valid,
    output logic [DW-1:0] head_data
);
    logic [DW-1:0] mem_reg [2];
    logic       wr_reg;
    logic       rd_reg;
    logic [1:0] count_reg;

    assign full = (count_reg == 2'd2);
    assign head_valid = (count_reg != 2'd0);
    assign head_data = mem_reg[rd_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg    <= 1'b0;
            rd_reg    <= 1'b0;
            count_reg <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_reg <= !wr_reg;
            end
            if (pop)
            begin
                rd_reg <= !rd_reg;
            end
            count_reg <= count_reg + {1'b0, push} - {1'b0, pop};
        end
    end

    `MADI_NEVER(a_count_range, clk, rst_n, count_reg == 2'd3)
    `MADI_NEVER(a_pop_empty, clk, rst_n, pop && !head_valid)
    `MADI_NEVER(a_push_full, clk, rst_n, push && full)
    `MADI_ASSERT(a_count_up, clk, rst_n, (push && !pop) |=> (count_reg == $past(count_reg) + 2'd1))

endmodule

/* hw/rtl/madi_back.sv */
// back: flush sequencing, detector, edge-directed average, clamp, output register
// depends on madi_pkg
module madi_back import madi_pkg::*; #(
    parameter int MASK_REACH = 3
) (
    input  logic clk,
    input  logic rst_n,
    input  logic q_valid,
    output logic q_pop,
    input  logic [2 + (2 * MASK_REACH + 3) * (1 + $bits(col_t)) - 1:0] q_data,
    input  logic [15:0] motion_thr,
    input  logic [15:0] comb_thr,
    input  logic [15:0] floor_thr,
    output logic out_valid,
    input  logic out_ready,
    output logic [15:0] out_pixel,
    output logic out_interp,
    output logic out_last
);
    localparam int WIN = 2 * MASK_REACH + 3;
    localparam int S = MASK_REACH + 1;
    localparam int CW = $bits(col_t);

    // current job, shifted toward older slots during a flush so slot S is always emitted
    col_t           cur_win_reg [WIN];
    logic [WIN-1:0] cur_valid_reg;
    logic           cur_held_reg;
    logic           cur_last_reg;
    logic           busy_reg;

    logic a_valid_reg, a_hit_reg, a_edge_reg, a_last_reg;
    logic [17:0] a_s0_reg, a_s1_reg, a_s2_reg;
    logic [15:0] a_um_reg, a_uc_reg, a_up_reg, a_lm_reg, a_lc_reg, a_lp_reg;
    logic [15:0] a_w_reg, a_o_reg, a_td_reg;

    logic        o_valid_reg, o_interp_reg, o_last_reg;
    logic [15:0] o_pixel_reg;

    logic o_ready, a_ready, step, issue, step_done, more_left;
    logic hit, edge_ok;
    logic [WIN-1:0] det;
    logic [17:0] sc [3];

    assign o_ready = !o_valid_reg || out_ready;
    assign a_ready = !a_valid_reg || o_ready;
    assign step = busy_reg && a_ready;
    assign issue = step && cur_valid_reg[S];
    assign more_left = |cur_valid_reg[S-1:0];
    assign step_done = step && (!cur_last_reg || !more_left);
    assign q_pop = q_valid && (!busy_reg || step_done);

    always_comb
    begin
        logic [17:0] ts, cs, tl, cl;
        logic [1:0]  cnt;
        det = '0;
        for (int t = 1; t < WIN - 1; t++)
        begin
            ts = {2'b0, cur_win_reg[t].tdiff};
            cs = {2'b0, cur_win_reg[t].cdiff};
            if (cur_valid_reg[t-1])
            begin
                ts = ts + {2'b0, cur_win_reg[t-1].tdiff};
                cs = cs + {2'b0, cur_win_reg[t-1].cdiff};
            end
            if (cur_valid_reg[t+1])
            begin
                ts = ts + {2'b0, cur_win_reg[t+1].tdiff};
                cs = cs + {2'b0, cur_win_reg[t+1].cdiff};
            end
            cnt = 2'd1 + {1'b0, cur_valid_reg[t-1]} + {1'b0, cur_valid_reg[t+1]};
            tl = {1'b0, motion_thr, 1'b0};
            cl = {1'b0, comb_thr, 1'b0};
            if (cnt == 2'd3)
            begin
                tl = tl + {2'b0, motion_thr};
                cl = cl + {2'b0, comb_thr};
            end
            else if (cnt == 2'd1)
            begin
                tl = {2'b0, motion_thr};
                cl = {2'b0, comb_thr};
            end
            det[t] = cur_valid_reg[t] && (ts > tl) && (cs > cl);
        end
        hit = 1'b0;
        for (int t = S - MASK_REACH; t <= S + MASK_REACH; t++)
        begin
            hit = hit | det[t];
        end
        edge_ok = cur_valid_reg[S-2] && cur_valid_reg[S+2];
        for (int d = -1; d <= 1; d++)
        begin
            sc[d+1] = '0;
            for (int off = -1; off <= 1; off++)
            begin
                sc[d+1] = sc[d+1] + {2'b0, absdiff16(cur_win_reg[S-off+d].upper,
                                                     cur_win_reg[S-off-d].lower)};
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            for (int i = 0; i < WIN; i++)
            begin
                cur_win_reg[i] <= q_data[i*CW +: CW];
            end
            cur_held_reg <= q_data[WIN*CW + WIN];
            cur_last_reg <= q_data[WIN*CW + WIN + 1];
        end
        else if (step)
        begin
            for (int i = 1; i < WIN; i++)
            begin
                cur_win_reg[i] <= cur_win_reg[i-1];
            end
        end
        if (issue)
        begin
            a_hit_reg  <= cur_held_reg && hit;
            a_edge_reg <= edge_ok;
            a_last_reg <= cur_last_reg && !more_left;
            a_s0_reg   <= sc[0];
            a_s1_reg   <= sc[1];
            a_s2_reg   <= sc[2];
            a_um_reg   <= cur_win_reg[S-1].upper;
            a_uc_reg   <= cur_win_reg[S].upper;
            a_up_reg   <= cur_win_reg[S+1].upper;
            a_lm_reg   <= cur_win_reg[S-1].lower;
            a_lc_reg   <= cur_win_reg[S].lower;
            a_lp_reg   <= cur_win_reg[S+1].lower;
            a_w_reg    <= cur_win_reg[S].weave;
            a_o_reg    <= cur_win_reg[S].other;
            a_td_reg   <= cur_win_reg[S].tdiff;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            cur_valid_reg <= '0;
            a_valid_reg   <= 1'b0;
        end
        else
        begin
            if (q_pop)
            begin
                busy_reg      <= 1'b1;
                cur_valid_reg <= q_data[WIN*CW +: WIN];
            end
            else if (step_done)
            begin
                busy_reg <= 1'b0;
            end
            else if (step)
            begin
                cur_valid_reg <= {cur_valid_reg[WIN-2:0], 1'b0};
            end
            if (a_ready)
            begin
                a_valid_reg <= issue;
            end
        end
    end

    // second stage: pick direction, clamp round the temporal mean
    logic [15:0] sp, ctr, half, lim;
    logic [17:0] best, lo, hi, v;
    logic [1:0]  dsel;
    logic [15:0] pix;

    always_comb
    begin
        best = a_s0_reg;
        dsel = 2'd0;
        if (a_s1_reg < best)
        begin
            best = a_s1_reg;
            dsel = 2'd1;
        end
        if (a_s2_reg < best)
        begin
            dsel = 2'd2;
        end
        if (!a_edge_reg)
        begin
            sp = avg2(a_uc_reg, a_lc_reg);
        end
        else
        begin
            unique case (dsel)
                2'd0:    sp = avg2(a_um_reg, a_lp_reg);
                2'd1:    sp = avg2(a_uc_reg, a_lc_reg);
                default: sp = avg2(a_up_reg, a_lm_reg);
            endcase
        end
        ctr  = avg2(a_w_reg, a_o_reg);
        half = {1'b0, a_td_reg[15:1]};
        lim  = (half < floor_thr) ? floor_thr : half;
        lo   = {2'b0, ctr} - {2'b0, lim};
        hi   = {2'b0, ctr} + {2'b0, lim};
        v    = {2'b0, sp};
        if ($signed(v) < $signed(lo))
        begin
            v = lo;
        end
        if ($signed(v) > $signed(hi))
        begin
            v = hi;
        end
        if (v[17])
        begin
            pix = 16'd0;
        end
        else if (v[16])
        begin
            pix = 16'hffff;
        end
        else
        begin
            pix = v[15:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (o_ready && a_valid_reg)
        begin
            o_pixel_reg  <= a_hit_reg ? pix : a_w_reg;
            o_interp_reg <= a_hit_reg;
            o_last_reg   <= a_last_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            o_valid_reg <= 1'b0;
        end
        else if (o_ready)
        begin
            o_valid_reg <= a_valid_reg;
        end
    end

    assign out_valid  = o_valid_reg;
    assign out_pixel  = o_pixel_reg;
    assign out_interp = o_interp_reg;
    assign out_last   = o_last_reg;

endmodule
